### hw/rtl/table_xor_seed_random_range_macros.svh
// Assertion macros for the tsr block.
`ifndef TABLE_XOR_SEED_RANDOM_RANGE_MACROS_SVH
`define TABLE_XOR_SEED_RANDOM_RANGE_MACROS_SVH

// Same-cycle implication.
`define TSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/tsr_pkg.sv
package tsr_pkg;

   localparam int SEED_BITS     = 32;
   localparam int WORD_BITS     = 31;
   localparam int SLOT_BITS     = 4;
   localparam int FRACTION_BITS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int SPAN_BITS     = 34;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam int STATE_BITS = 3;
   typedef logic [STATE_BITS-1:0] state_type;

   localparam state_type S_IDLE = 3'd0;
   localparam state_type S_RD0  = 3'd1;
   localparam state_type S_RD1  = 3'd2;
   localparam state_type S_RD2  = 3'd3;
   localparam state_type S_RD3  = 3'd4;
   localparam state_type S_DIV  = 3'd5;
   localparam state_type S_FIN  = 3'd6;

endpackage

### hw/rtl/tsr_ram.sv
module tsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/table_xor_seed_random_range.sv
// A query, once accepted, makes three table reads through one RAM port, then computes
// one remainder bit per cycle in a shared compare/subtract unit. An inverted range skips
// the division. A new query is not accepted until the last one has finished.
// Throughput: one load per cycle while idle (no query in flight).
// Reset: synchronous, clears the sequencer and rsp_valid; table contents are not
// cleared and are undefined until loaded.
`include "table_xor_seed_random_range_macros.svh"

module table_xor_seed_random_range
   import tsr_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int INDEX_BITS  = 4,
   parameter int ENTRY_BITS  = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [SLOT_BITS-1:0]         req_slot,
   input  logic [WORD_BITS-1:0]         req_entry_word,
   input  logic signed [SEED_BITS-1:0]  req_seed,
   input  logic signed [VALUE_BITS-1:0] req_range_low,
   input  logic signed [VALUE_BITS-1:0] req_range_high,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [WORD_BITS-1:0]         rsp_raw_value,
   output logic [FRACTION_BITS-1:0]     rsp_fraction,
   output logic signed [VALUE_BITS-1:0] rsp_ranged_value,
   output logic                         rsp_range_error
);

   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int WRAP_BITS  = (INDEX_BITS > SLOT_BITS) ? INDEX_BITS : SLOT_BITS;
   localparam int MAG_BITS   = 3 * INDEX_BITS;
   localparam int CNT_BITS   = $clog2(ENTRY_BITS);
   localparam int REM_BITS   = VALUE_BITS + 1;
   localparam int WRAP_SHIFT = WRAP_BITS + ADDR_BITS;
   localparam int RECIP_BITS = WRAP_SHIFT + 1;
   localparam int PROD_BITS  = WRAP_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] WRAP_RECIP = RECIP_BITS'(
      ((longint'(1) << WRAP_SHIFT) + longint'(TABLE_DEPTH) - 1) / longint'(TABLE_DEPTH));
   localparam logic [CNT_BITS-1:0] CNT_LAST  = CNT_BITS'(ENTRY_BITS - 1);

   // index modulo depth by reciprocal multiply
   function automatic logic [ADDR_BITS-1:0] wrap_index(input logic [WRAP_BITS-1:0] v);
      logic [PROD_BITS-1:0]  p;
      logic [WRAP_BITS-1:0]  q;
      logic [WRAP_SHIFT-1:0] r;
      p = PROD_BITS'(v) * PROD_BITS'(WRAP_RECIP);
      q = WRAP_BITS'(p >> WRAP_SHIFT);
      r = WRAP_SHIFT'(v) - WRAP_SHIFT'(q) * WRAP_SHIFT'(TABLE_DEPTH);
      return r[ADDR_BITS-1:0];
   endfunction

   state_type                 state_ff, state_in;
   logic [MAG_BITS-1:0]       mag_ff, mag_in;
   logic [VALUE_BITS-1:0]     lo_ff, lo_in;
   logic [REM_BITS-1:0]       span_ff, span_in;
   logic                      err_ff, err_in;
   logic [ENTRY_BITS-1:0]     acc_ff, acc_in;
   logic [ENTRY_BITS-1:0]     dvd_ff, dvd_in;
   logic [REM_BITS-1:0]       rem_ff, rem_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_BITS-1:0]     raw_out_ff, raw_out_in;
   logic [VALUE_BITS-1:0]     ranged_out_ff, ranged_out_in;
   logic                      err_out_ff, err_out_in;

   logic [SEED_BITS-1:0]      seed_mag;
   logic [SPAN_BITS-1:0]      span_full;
   logic [REM_BITS:0]         trial;
   logic [ENTRY_BITS-1:0]     rd_data;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic                      wr_en;
   logic [ENTRY_BITS-1:0]     acc_last;

   assign req_ready = (state_ff == S_IDLE);
   assign wr_en     = req_valid && req_ready && (req_cmd == CMD_LOAD);

   assign seed_mag  = req_seed[SEED_BITS-1] ? (SEED_BITS'(0) - req_seed) : req_seed;
   assign span_full = SPAN_BITS'(req_range_high) - SPAN_BITS'(req_range_low)
                      + SPAN_BITS'(1);
   assign trial     = {rem_ff, dvd_ff[ENTRY_BITS-1]};
   assign acc_last  = acc_ff ^ rd_data;

   always_comb begin
      case (state_ff)
         S_RD1:   rd_addr = wrap_index(WRAP_BITS'(mag_ff[2*INDEX_BITS-1:INDEX_BITS]));
         S_RD2:   rd_addr = wrap_index(WRAP_BITS'(mag_ff[3*INDEX_BITS-1:2*INDEX_BITS]));
         default: rd_addr = wrap_index(WRAP_BITS'(mag_ff[INDEX_BITS-1:0]));
      endcase
   end

   tsr_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wrap_index(WRAP_BITS'(req_slot))),
      .wr_data(req_entry_word[ENTRY_BITS-1:0]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      lo_in         = lo_ff;
      span_in       = span_ff;
      err_in        = err_ff;
      acc_in        = acc_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      raw_out_in    = raw_out_ff;
      ranged_out_in = ranged_out_ff;
      err_out_in    = err_out_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_cmd == CMD_QUERY)) begin
               mag_in   = seed_mag[MAG_BITS-1:0];
               lo_in    = req_range_low;
               span_in  = span_full[REM_BITS-1:0];
               err_in   = span_full[SPAN_BITS-1] || (span_full == '0);
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            acc_in   = rd_data;
            state_in = S_RD2;
         end
         S_RD2: begin
            acc_in   = acc_last;
            state_in = S_RD3;
         end
         S_RD3: begin
            acc_in   = acc_last;
            dvd_in   = acc_last;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = err_ff ? S_FIN : S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, span_ff}) begin
               rem_in = REM_BITS'(trial - {1'b0, span_ff});
            end else begin
               rem_in = trial[REM_BITS-1:0];
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               raw_out_in    = acc_ff;
               ranged_out_in = err_ff ? lo_ff : (rem_ff[VALUE_BITS-1:0] + lo_ff);
               err_out_in    = err_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      lo_ff         <= lo_in;
      span_ff       <= span_in;
      err_ff        <= err_in;
      acc_ff        <= acc_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      raw_out_ff    <= raw_out_in;
      ranged_out_ff <= ranged_out_in;
      err_out_ff    <= err_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = WORD_BITS'(raw_out_ff);
   assign rsp_fraction     = raw_out_ff[FRACTION_BITS-1:0];
   assign rsp_ranged_value = ranged_out_ff;
   assign rsp_range_error  = err_out_ff;

   `TSR_ASSERT_NEXT(a_query_starts_read, clock, reset,
      req_valid && req_ready && (req_cmd == CMD_QUERY), state_ff == S_RD0,
      "query beat did not start the table reads")
   `TSR_ASSERT_NOW(a_rem_below_span, clock, reset,
      state_ff == S_DIV, rem_ff < span_ff,
      "partial remainder not below span")
   `TSR_ASSERT_NOW(a_div_count_bound, clock, reset,
      state_ff == S_DIV, cnt_ff <= CNT_LAST,
      "division step count overran")
   `TSR_ASSERT_NOW(a_no_error_in_div, clock, reset,
      state_ff == S_DIV, !err_ff,
      "division running on an inverted range")

endmodule
